// ----- rtl/apfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apfc_pkg
// Shared types, format codes and constants of the ARGB pixel format converter.
// ----------------------------------------------------------------------------
package apfc_pkg;

    typedef enum logic [1:0] {
        FMT_I4  = 2'd0,
        FMT_I8  = 2'd1,
        FMT_I16 = 2'd2,
        FMT_F32 = 2'd3
    } t_fmt;

    localparam logic [0:0] REG_SRC_FMT = 1'b0;
    localparam logic [0:0] REG_DST_FMT = 1'b1;

    // Single-precision reciprocals of 15, 255 and 65535.
    localparam logic [31:0] RECIP_15    = 32'h3D888889;
    localparam logic [31:0] RECIP_255   = 32'h3B808081;
    localparam logic [31:0] RECIP_65535 = 32'h37800080;

    // Per-channel control carried down the pipe.
    typedef struct packed {
        t_fmt sf;
        t_fmt df;
    } t_ctl;

    function automatic logic [15:0] fmt_max(input t_fmt f);
        case (f)
            FMT_I4:  fmt_max = 16'h000F;
            FMT_I8:  fmt_max = 16'h00FF;
            default: fmt_max = 16'hFFFF;
        endcase
    endfunction

    function automatic logic [23:0] fmt_recip_mant(input t_fmt f);
        case (f)
            FMT_I4:  fmt_recip_mant = {1'b1, RECIP_15[22:0]};
            FMT_I8:  fmt_recip_mant = {1'b1, RECIP_255[22:0]};
            default: fmt_recip_mant = {1'b1, RECIP_65535[22:0]};
        endcase
    endfunction

    function automatic logic [7:0] fmt_recip_exp(input t_fmt f);
        case (f)
            FMT_I4:  fmt_recip_exp = RECIP_15[30:23];
            FMT_I8:  fmt_recip_exp = RECIP_255[30:23];
            default: fmt_recip_exp = RECIP_65535[30:23];
        endcase
    endfunction

endpackage

// ----- rtl/apfc_chan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apfc_chan
// Four-stage conversion pipe for one channel.
//   S1: decode, integer normalize / float unpack
//   S2: 24x24 (or integer) multiply
//   S3: normalize, round (to float) or scale shift and saturate (to int)
//   S4: output register
// ----------------------------------------------------------------------------
module apfc_chan
    import apfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_adv,
    input  t_ctl        i_ctl,
    input  logic [31:0] i_val,
    output logic [31:0] o_val
);

    // Integer rescale multipliers. Scale-up uses the exact ratio dmax/smax;
    // scale-down uses a rounded-up reciprocal so the top bits give the floor.
    localparam logic [23:0] MUL_4_8  = 24'd17;
    localparam logic [23:0] MUL_4_16 = 24'd4369;
    localparam logic [23:0] MUL_8_16 = 24'd257;
    localparam logic [23:0] MUL_8_4  = 24'd3856;    // floor(v/17)   = (v*M)>>16, v<=255
    localparam logic [23:0] MUL_16_4 = 24'hF0010;   // floor(v/4369) = (v*M)>>32
    localparam logic [23:0] MUL_16_8 = 24'hFF0100;  // floor(v/257)  = (v*M)>>32
    localparam logic [23:0] MUL_COPY = 24'd1;

    // ---------------- stage 1 ----------------
    t_ctl        r_ctl1;
    logic [31:0] r_raw1;
    logic [23:0] r_ma1;      // multiplicand A
    logic [23:0] r_mb1;      // multiplicand B
    logic [8:0]  r_ea1;      // biased exponent of product before normalize
    logic        r_zero1;
    logic        r_neg1;
    logic        r_nan1;
    logic        r_inf1;

    logic [15:0] s1_iv;
    logic [4:0]  s1_lz;
    logic [23:0] s1_norm;
    logic [23:0] n_ma1;
    logic [23:0] n_mb1;
    logic [8:0]  n_ea1;
    logic        n_zero1;

    always_comb begin
        s1_iv   = i_val[15:0] & fmt_max(i_ctl.sf);
        s1_lz   = 5'd0;
        for (int k = 0; k < 16; k++) begin
            if (s1_iv[k]) s1_lz = 5'(15 - k);
        end
        s1_norm = {s1_iv << s1_lz, 8'd0};
        n_ma1   = '0;
        n_mb1   = '0;
        n_ea1   = '0;
        n_zero1 = 1'b0;
        if (i_ctl.sf == FMT_F32) begin
            // float * dmax; dmax = 1.m * 2^e
            n_ma1   = {(i_val[30:23] != 8'd0), i_val[22:0]};
            n_zero1 = (i_val[30:23] == 8'd0);
            case (i_ctl.df)
                FMT_I4:  begin n_mb1 = 24'hF00000; n_ea1 = 9'(i_val[30:23]) + 9'd3;  end
                FMT_I8:  begin n_mb1 = 24'hFF0000; n_ea1 = 9'(i_val[30:23]) + 9'd7;  end
                default: begin n_mb1 = 24'hFFFF00; n_ea1 = 9'(i_val[30:23]) + 9'd15; end
            endcase
        end else if (i_ctl.df == FMT_F32) begin
            n_ma1   = s1_norm;
            n_mb1   = fmt_recip_mant(i_ctl.sf);
            n_zero1 = (s1_iv == 16'd0);
            n_ea1   = 9'(fmt_recip_exp(i_ctl.sf)) + 9'(5'd15 - s1_lz);
        end else begin
            // integer path: plain product in low bits
            n_ma1 = {8'd0, s1_iv};
            case ({i_ctl.sf, i_ctl.df})
                {FMT_I4,  FMT_I8}:  n_mb1 = MUL_4_8;
                {FMT_I4,  FMT_I16}: n_mb1 = MUL_4_16;
                {FMT_I8,  FMT_I16}: n_mb1 = MUL_8_16;
                {FMT_I8,  FMT_I4}:  n_mb1 = MUL_8_4;
                {FMT_I16, FMT_I4}:  n_mb1 = MUL_16_4;
                {FMT_I16, FMT_I8}:  n_mb1 = MUL_16_8;
                default:            n_mb1 = MUL_COPY;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl1  <= i_ctl;
            r_raw1  <= i_val;
            r_ma1   <= n_ma1;
            r_mb1   <= n_mb1;
            r_ea1   <= n_ea1;
            r_zero1 <= n_zero1;
            r_neg1  <= i_val[31];
            r_nan1  <= (i_val[30:23] == 8'hFF) && (i_val[22:0] != 23'd0);
            r_inf1  <= (i_val[30:23] == 8'hFF) && (i_val[22:0] == 23'd0);
        end
    end

    // ---------------- stage 2 ----------------
    t_ctl        r_ctl2;
    logic [31:0] r_raw2;
    logic [47:0] r_prod2;
    logic [8:0]  r_ea2;
    logic        r_zero2;
    logic        r_neg2;
    logic        r_nan2;
    logic        r_inf2;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl2  <= r_ctl1;
            r_raw2  <= r_raw1;
            r_prod2 <= r_ma1 * r_mb1;
            r_ea2   <= r_ea1;
            r_zero2 <= r_zero1;
            r_neg2  <= r_neg1;
            r_nan2  <= r_nan1;
            r_inf2  <= r_inf1;
        end
    end

    // ---------------- stage 3 ----------------
    // Float product: normalize to 24 bits with round-to-nearest-even.
    logic        s3_top;
    logic [23:0] s3_mant;
    logic        s3_g;
    logic        s3_st;
    logic [24:0] s3_rnd;
    logic [9:0]  s3_exp;
    logic [31:0] s3_fbits;
    logic [15:0] s3_ires;     // integer result for int destination
    logic        s3_sat;
    logic        s3_izero;
    logic [9:0]  s3_ue;       // unbiased exponent + offset
    logic [15:0] s3_dmax;
    logic [39:0] s3_shl;

    always_comb begin
        s3_top  = r_prod2[47];
        s3_mant = s3_top ? r_prod2[47:24] : r_prod2[46:23];
        s3_g    = s3_top ? r_prod2[23] : r_prod2[22];
        s3_st   = s3_top ? (r_prod2[22:0] != 23'd0) : (r_prod2[21:0] != 22'd0);
        s3_rnd  = {1'b0, s3_mant} + 25'((s3_g && (s3_st || s3_mant[0])) ? 1 : 0);
        // int to float: ea is already biased; bump for top bit and rounding carry
        s3_exp  = 10'(r_ea2) + 10'(s3_top) + 10'(s3_rnd[24]);
        s3_fbits = {1'b0, s3_exp[7:0], s3_rnd[24] ? s3_rnd[23:1] : s3_rnd[22:0]};

        s3_dmax  = fmt_max(r_ctl2.df);
        s3_ires  = '0;
        s3_sat   = 1'b0;
        s3_izero = 1'b0;
        s3_ue    = 10'(r_ea2) - 10'd127 + 10'(s3_top) + 10'(s3_rnd[24]);
        s3_shl   = '0;
        if (r_ctl2.sf == FMT_F32) begin
            // scaled single = 1.m * 2^ue
            if (r_nan2 || r_neg2 || r_zero2) begin
                s3_izero = 1'b1;
            end else if (r_inf2 || (!s3_ue[9] && s3_ue >= 10'd16)) begin
                s3_sat = 1'b1;
            end else if (s3_ue[9]) begin
                s3_izero = 1'b1;
            end else begin
                s3_shl  = 40'({s3_rnd[24] ? 24'h800000 : s3_rnd[23:0]}) << s3_ue[3:0];
                s3_ires = s3_shl[38:23];
                if (s3_shl[38:23] >= s3_dmax) s3_sat = 1'b1;
            end
        end else begin
            // scale-down keeps the high bits of the reciprocal product
            case ({r_ctl2.sf, r_ctl2.df})
                {FMT_I8,  FMT_I4}: s3_ires = {12'd0, r_prod2[19:16]};
                {FMT_I16, FMT_I4}: s3_ires = {12'd0, r_prod2[35:32]};
                {FMT_I16, FMT_I8}: s3_ires = {8'd0, r_prod2[39:32]};
                default:           s3_ires = r_prod2[15:0];
            endcase
        end
    end

    logic [31:0] r_res3;
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (r_ctl2.sf == FMT_F32 && r_ctl2.df == FMT_F32)
                r_res3 <= r_raw2;
            else if (r_ctl2.df == FMT_F32)
                r_res3 <= r_zero2 ? 32'd0 : s3_fbits;
            else if (s3_izero)
                r_res3 <= 32'd0;
            else if (s3_sat)
                r_res3 <= {16'd0, s3_dmax};
            else
                r_res3 <= {16'd0, s3_ires};
        end
    end

    // ---------------- stage 4 ----------------
    logic [31:0] r_res4;
    always_ff @(posedge i_clk) begin
        if (i_adv) r_res4 <= r_res3;
    end

    assign o_val = r_res4;

endmodule

// ----- rtl/argb_pixel_format_converter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_pixel_format_converter_core
// Converts one ARGB pixel per clock between 4/8/16-bit integer and float32.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   input    | i_start / o_busy       | i_src_alpha..blue, i_in_last
//   result   | o_valid (strobe)       | o_dst_alpha..blue, o_out_last
//   config   | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One pixel enters per cycle; its result strobes at the output of the
// four-stage multiply/normalize pipe of each channel.
// Reset (synchronous, low) clears valid bits and sets both formats to 8-bit.
// The receiver cannot stall, so o_busy stays low and the pipe always advances.
// ----------------------------------------------------------------------------
module argb_pixel_format_converter_core
    import apfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_src_alpha,
    input  logic [31:0] i_src_red,
    input  logic [31:0] i_src_green,
    input  logic [31:0] i_src_blue,
    input  logic        i_in_last,
    output logic        o_valid,
    output logic [31:0] o_dst_alpha,
    output logic [31:0] o_dst_red,
    output logic [31:0] o_dst_green,
    output logic [31:0] o_dst_blue,
    output logic        o_out_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data
);

    localparam int STAGES = 4;

    t_fmt r_src_fmt;
    t_fmt r_dst_fmt;
    t_ctl w_ctl;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] r_last;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_ctl       = '{sf: r_src_fmt, df: r_dst_fmt};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= FMT_I8;
            r_dst_fmt <= FMT_I8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SRC_FMT: r_src_fmt <= t_fmt'(i_cfg_data);
                REG_DST_FMT: r_dst_fmt <= t_fmt'(i_cfg_data);
                default:     ;
            endcase
        end
    end

    // valid and last marks travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[STAGES-2:0], i_in_last};
    end

    apfc_chan u_alpha (.i_clk, .i_adv(1'b1), .i_ctl(w_ctl), .i_val(i_src_alpha),
                       .o_val(o_dst_alpha));
    apfc_chan u_red   (.i_clk, .i_adv(1'b1), .i_ctl(w_ctl), .i_val(i_src_red),
                       .o_val(o_dst_red));
    apfc_chan u_green (.i_clk, .i_adv(1'b1), .i_ctl(w_ctl), .i_val(i_src_green),
                       .o_val(o_dst_green));
    apfc_chan u_blue  (.i_clk, .i_adv(1'b1), .i_ctl(w_ctl), .i_val(i_src_blue),
                       .o_val(o_dst_blue));

    assign o_valid    = r_vld[STAGES-1];
    assign o_out_last = r_last[STAGES-1];

endmodule

// ----- rtl/apfc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apfc_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module apfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_valid,
    input logic        i_in_last,
    input logic        o_out_last
);

    // every accepted request yields a result
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##4 o_valid) else $error("result missing");

    // no result without a request
    a_nospur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_start) |-> ##4 !o_valid) else $error("spurious result");

    // last mark follows its pixel
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_in_last) |-> ##4 o_out_last) else $error("last mark lost");

endmodule

bind argb_pixel_format_converter_core apfc_checker u_apfc_checker (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_valid, .i_in_last, .o_out_last
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for argb_pixel_format_converter_core: a directed table
// of conversions, then random pixels over every source/target format pair,
// each checked per channel against a typed-in pixel or a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb;
    import apfc_pkg::*;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        logic        last;
    } t_pix;

    // One directed request; chk set means the expected pixel is typed in.
    typedef struct packed {
        t_fmt        sf;
        t_fmt        df;
        logic        chk;
        t_pix        px;
        t_pix        want;
    } t_row;

    localparam int NUM_ROWS  = 18;
    localparam int WDOG_MAX  = 1000;
    localparam int PIPE_WAIT = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [31:0] i_src_alpha;
    logic [31:0] i_src_red;
    logic [31:0] i_src_green;
    logic [31:0] i_src_blue;
    logic        i_in_last;
    logic        o_valid;
    logic [31:0] o_dst_alpha;
    logic [31:0] o_dst_red;
    logic [31:0] o_dst_green;
    logic [31:0] o_dst_blue;
    logic        o_out_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [1:0]  i_cfg_data;

    t_pix        pixels_due[$];
    int          err_count;
    int          idle_cycles;
    bit          gaps_on;
    t_fmt        cur_sf;
    t_fmt        cur_df;

    argb_pixel_format_converter_core dut (.*);

    // Directed conversions: integer rescales, masking, copies, float saturation
    t_row rows [NUM_ROWS] = '{
        // reset formats are 8-bit to 8-bit
        '{FMT_I8,  FMT_I8,  1'b1, '{32'hFFFFFFFF, 32'h0, 32'h12345680, 32'hA5, 1'b1},
                                  '{32'hFF, 32'h0, 32'h80, 32'hA5, 1'b1}},
        '{FMT_I4,  FMT_I8,  1'b1, '{32'hF, 32'h0, 32'h7, 32'hFFFFFFF3, 1'b0},
                                  '{32'hFF, 32'h0, 32'h77, 32'h33, 1'b0}},
        '{FMT_I8,  FMT_I4,  1'b1, '{32'hFF, 32'h0, 32'h11, 32'h10, 1'b1},
                                  '{32'hF, 32'h0, 32'h1, 32'h0, 1'b1}},
        // alpha goes through the 16-bit layout like the other channels
        '{FMT_I16, FMT_I8,  1'b1, '{32'hFFFF, 32'h0, 32'h1FF, 32'h0101, 1'b0},
                                  '{32'hFF, 32'h0, 32'h1, 32'h1, 1'b0}},
        '{FMT_I8,  FMT_I16, 1'b1, '{32'hFF, 32'h0, 32'h1, 32'h80, 1'b0},
                                  '{32'hFFFF, 32'h0, 32'h101, 32'h8080, 1'b0}},
        '{FMT_I4,  FMT_I16, 1'b1, '{32'hF, 32'h1, 32'h0, 32'h8, 1'b1},
                                  '{32'hFFFF, 32'h1111, 32'h0, 32'h8888, 1'b1}},
        '{FMT_I16, FMT_I4,  1'b1, '{32'hFFFF, 32'h1111, 32'h1110, 32'h0, 1'b0},
                                  '{32'hF, 32'h1, 32'h0, 32'h0, 1'b0}},
        '{FMT_I4,  FMT_I4,  1'b1, '{32'hFFFFFFFF, 32'h10, 32'h5, 32'hA, 1'b0},
                                  '{32'hF, 32'h0, 32'h5, 32'hA, 1'b0}},
        '{FMT_I16, FMT_I16, 1'b1, '{32'hFFFFFFFF, 32'h10000, 32'h1234, 32'hABCD0001, 1'b1},
                                  '{32'hFFFF, 32'h0, 32'h1234, 32'h1, 1'b1}},
        // float copy keeps NaN, infinity and signed zero bit patterns
        '{FMT_F32, FMT_F32, 1'b1, '{32'h7FC00001, 32'hFF800000, 32'h3F800000, 32'h80000000, 1'b0},
                                  '{32'h7FC00001, 32'hFF800000, 32'h3F800000, 32'h80000000, 1'b0}},
        '{FMT_F32, FMT_I8,  1'b1, '{32'h3F800000, 32'hBF800000, 32'h7FC00000, 32'h7F800000, 1'b0},
                                  '{32'hFF, 32'h0, 32'h0, 32'hFF, 1'b0}},
        '{FMT_F32, FMT_I8,  1'b1, '{32'h3F000000, 32'h0, 32'h40000000, 32'h00000001, 1'b1},
                                  '{32'h7F, 32'h0, 32'hFF, 32'h0, 1'b1}},
        '{FMT_F32, FMT_I4,  1'b1, '{32'h3F800000, 32'h3F000000, 32'h80000000, 32'h7F7FFFFF, 1'b0},
                                  '{32'hF, 32'h7, 32'h0, 32'hF, 1'b0}},
        '{FMT_F32, FMT_I16, 1'b0, '{32'h3F800000, 32'h3F000000, 32'h3F7FFFFF, 32'hFFC00000, 1'b0},
                                  '0},
        '{FMT_I8,  FMT_F32, 1'b0, '{32'h0, 32'hFF, 32'h1, 32'h80, 1'b1}, '0},
        '{FMT_I4,  FMT_F32, 1'b0, '{32'hF, 32'h1, 32'h7, 32'hFFFFFFF0, 1'b0}, '0},
        '{FMT_I16, FMT_F32, 1'b0, '{32'hFFFF, 32'h1, 32'h8000, 32'hFFFF0000, 1'b0}, '0},
        '{FMT_F32, FMT_I16, 1'b0, '{32'h477FFF00, 32'h3DCCCCCD, 32'h00800000, 32'hC2000000, 1'b1},
                                  '0}
    };

    // ------------------------------------------------------------------
    // Conversion predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] chan_max(input t_fmt f);
        case (f)
            FMT_I4:  return 32'hF;
            FMT_I8:  return 32'hFF;
            default: return 32'hFFFF;
        endcase
    endfunction

    // Round p * 2^e to a 24-bit significand, nearest even; result m * 2^ex
    function automatic void round_single(input logic [63:0] p, input int e,
                                         output logic [23:0] m, output int ex);
        int          k;
        int          sh;
        logic [63:0] rem;
        logic [63:0] half;
        logic [24:0] mm;
        k = 63;
        while (k > 0 && !p[k]) k--;
        if (k <= 23) begin
            m  = p[23:0] << (23 - k);
            ex = e - (23 - k);
        end else begin
            sh   = k - 23;
            mm   = 25'(p >> sh);
            rem  = p & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && mm[0])) mm++;
            if (mm[24]) begin
                mm = mm >> 1;
                sh++;
            end
            m  = mm[23:0];
            ex = e + sh;
        end
    endfunction

    // Integer channel times the single reciprocal of the source maximum
    function automatic logic [31:0] int_to_float(input logic [31:0] iv, input t_fmt sf);
        logic [31:0] rc;
        logic [23:0] m;
        int          ex;
        case (sf)
            FMT_I4:  rc = RECIP_15;
            FMT_I8:  rc = RECIP_255;
            default: rc = RECIP_65535;
        endcase
        if (iv == 0) return 32'h0;
        round_single(64'(iv) * 64'({1'b1, rc[22:0]}), int'(rc[30:23]) - 150, m, ex);
        return {1'b0, 8'(ex + 150), m[22:0]};
    endfunction

    // Float channel scaled in single precision, truncated and saturated
    function automatic logic [31:0] float_to_int(input logic [31:0] v, input t_fmt df);
        logic [31:0] dmax;
        logic [23:0] mant;
        logic [23:0] m;
        logic [63:0] val;
        int          ex;
        dmax = chan_max(df);
        if (v[30:23] == 8'hFF) return (v[22:0] != 0 || v[31]) ? 32'h0 : dmax;
        if (v[30:0] == 0 || v[31]) return 32'h0;
        mant = (v[30:23] == 0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
        round_single(64'(mant) * 64'(dmax),
                     ((v[30:23] == 0) ? 1 : int'(v[30:23])) - 150, m, ex);
        if (ex + 150 + 23 >= 255 || ex > 16) return dmax;
        if (ex >= 0) val = 64'(m) << ex;
        else if (ex <= -25) val = 64'h0;
        else val = 64'(m) >> (-ex);
        return (val >= 64'(dmax)) ? dmax : val[31:0];
    endfunction

    function automatic logic [31:0] convert_chan(input logic [31:0] v, input t_fmt sf,
                                                 input t_fmt df);
        logic [31:0] iv;
        if (sf == FMT_F32) return (df == FMT_F32) ? v : float_to_int(v, df);
        iv = v & chan_max(sf);
        if (df == FMT_F32) return int_to_float(iv, sf);
        if (df == sf) return iv;
        return 32'((64'(iv) * 64'(chan_max(df))) / 64'(chan_max(sf)));
    endfunction

    function automatic t_pix convert_pixel(input t_pix p, input t_fmt sf, input t_fmt df);
        t_pix q;
        q.a    = convert_chan(p.a, sf, df);
        q.r    = convert_chan(p.r, sf, df);
        q.g    = convert_chan(p.g, sf, df);
        q.b    = convert_chan(p.b, sf, df);
        q.last = p.last;
        return q;
    endfunction

    // Random channel value, biased toward the interesting part of the format
    function automatic logic [31:0] rand_chan(input t_fmt sf);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom;
        if (sf == FMT_F32) begin
            case (sel)
                1:       return {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom)};
                2:       return {1'($urandom_range(0, 1)), 8'h0, 23'($urandom)};
                3:       return {1'b0, 8'h7F, 23'h0};
                default: return {1'($urandom_range(0, 5) == 0),
                                 8'($urandom_range(100, 128)), 23'($urandom)};
            endcase
        end
        case (sel)
            1:       return 32'h0;
            2:       return chan_max(sf);
            default: return $urandom & chan_max(sf);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, mismatch reporting
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Request and config drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(input t_pix p, input t_pix want);
        i_start     <= 1'b1;
        i_src_alpha <= p.a;
        i_src_red   <= p.r;
        i_src_green <= p.g;
        i_src_blue  <= p.b;
        i_in_last   <= p.last;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        pixels_due.push_back(want);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic idx, input t_fmt f);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= f;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
    endtask

    // Formats change only with the pipe empty
    task automatic set_formats(input t_fmt sf, input t_fmt df);
        i_start <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
        cfg_write(REG_SRC_FMT, sf);
        if (gaps_on && $urandom_range(0, 1)) begin
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        cfg_write(REG_DST_FMT, df);
        i_cfg_valid <= 1'b0;
        cur_sf = sf;
        cur_df = df;
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pix want;
        if (i_rst_n && o_valid) begin
            if (pixels_due.size() == 0) begin
                report("result with no request outstanding");
            end else begin
                want = pixels_due.pop_front();
                if (o_dst_alpha !== want.a)
                    report($sformatf("alpha got %h want %h", o_dst_alpha, want.a));
                if (o_dst_red !== want.r)
                    report($sformatf("red got %h want %h", o_dst_red, want.r));
                if (o_dst_green !== want.g)
                    report($sformatf("green got %h want %h", o_dst_green, want.g));
                if (o_dst_blue !== want.b)
                    report($sformatf("blue got %h want %h", o_dst_blue, want.b));
                if (o_out_last !== want.last)
                    report($sformatf("last got %b want %b", o_out_last, want.last));
            end
        end
    end

    // Watchdog: cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_pix px;
        t_fmt sf;
        t_fmt df;
        err_count   = 0;
        idle_cycles = 0;
        gaps_on     = 1'b1;
        cur_sf      = FMT_I8;
        cur_df      = FMT_I8;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_src_alpha = '0;
        i_src_red   = '0;
        i_src_green = '0;
        i_src_blue  = '0;
        i_in_last   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_SRC_FMT;
        i_cfg_data  = FMT_I8;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (rows[i].sf != cur_sf || rows[i].df != cur_df)
                set_formats(rows[i].sf, rows[i].df);
            send_pixel(rows[i].px, rows[i].chk ? rows[i].want
                                               : convert_pixel(rows[i].px, cur_sf, cur_df));
        end

        // random phases: all sixteen format pairs first, then random pairs
        for (int ph = 0; ph < 20; ph++) begin
            if (ph < 16) begin
                sf = t_fmt'(ph / 4);
                df = t_fmt'(ph % 4);
            end else begin
                sf = t_fmt'($urandom_range(0, 3));
                df = t_fmt'($urandom_range(0, 3));
            end
            set_formats(sf, df);
            gaps_on = (ph < 18);
            repeat (60) begin
                px.a    = rand_chan(cur_sf);
                px.r    = rand_chan(cur_sf);
                px.g    = rand_chan(cur_sf);
                px.b    = rand_chan(cur_sf);
                px.last = ($urandom_range(0, 7) == 0);
                send_pixel(px, convert_pixel(px, cur_sf, cur_df));
            end
        end

        i_start <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/apfc_pkg.sv
rtl/apfc_chan.sv
rtl/argb_pixel_format_converter_core.sv
rtl/apfc_checker.sv
bench/tb.sv
